### sv/cdepm_pkg.sv
`timescale 1ns / 1ps
// Package for the CRC-driven entropy pool mixer.
// Holds command codes, widths and the CRC-16/CCITT byte step; no dependencies.
package cdepm_pkg;

    localparam int BYTE_W        = 8;
    localparam int CRC_W         = 16;
    localparam int CMD_W         = 2;
    localparam int RIDX_W        = 5;
    localparam int POOL_LOG2_DEF = 5;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef enum logic [CMD_W-1:0] {
        CMD_MIX   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // CRC-16/CCITT over one byte, MSB first, no reflection
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/crc_driven_entropy_pool_mixer_unit.sv
`timescale 1ns / 1ps
// Top level of the CRC-driven entropy pool mixer: pool memory, sequencer, CRC.
// Depends on cdepm_pkg.
//
// Usage
//   Input channel (i_valid / o_ready) carries one transaction per command:
//   mix a seed byte, read one pool entry, or clear the pool. Every
//   transaction returns exactly one result on the output channel
//   (o_valid / i_ready) with the pool byte (reads only, else 0) and the
//   running CRC after the command. i_seed_last is carried for framing and
//   does not affect the mixing.
//   The pool is a 2**POOL_LOG2 x 8 synchronous RAM with one write port and
//   two read ports. A mix needs three read-modify-writes (write position,
//   then the two CRC-chosen entries), one write per cycle, so a mix runs
//   through the steps IDLE, MIX2 and MIX3, a read through IDLE and RD2, and
//   a clear or unused command through IDLE alone; the second-target write
//   lands in the following IDLE step, alongside the next dispatch. The
//   result is registered in the last step of each command. A one-entry
//   input buffer lets the next transaction be accepted while the current
//   one is still in the sequencer.
//   Reset (synchronous, active low) empties all buffers, marks every pool
//   entry invalid (reads as zero), zeroes the write position, the CRC and
//   the CRC start register. A clear command does the same to the pool
//   at once via the per-entry valid bits.
//   When the receiver stalls, the result waits in the output register and
//   the sequencer holds its last step until the register frees up.
module crc_driven_entropy_pool_mixer_unit
    import cdepm_pkg::*;
#(
    parameter int POOL_LOG2 = POOL_LOG2_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [CRC_W-1:0]  i_cfg_data,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_seed_byte,
    input  logic              i_seed_last,
    input  logic [RIDX_W-1:0] i_read_index,
    // output channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_pool_byte,
    output logic [CRC_W-1:0]  o_crc_now
);

    localparam int POOL_SIZE = 1 << POOL_LOG2;

    typedef logic [POOL_LOG2-1:0] t_idx;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,   // dispatch from input buffer, first step
        ST_MIX2 = 4'b0010,   // add byte at write position
        ST_MIX3 = 4'b0100,   // XOR high byte into first target
        ST_RD2  = 4'b1000    // read data back
    } t_state;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;

    logic                r_in_vld;
    logic [CMD_W-1:0]    r_in_cmd;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [RIDX_W-1:0]   r_in_ridx;

    logic [BYTE_W-1:0]   r_cur_byte;
    t_idx                r_ta, r_tb, r_ridx;
    logic [BYTE_W-1:0]   r_va;

    t_idx                r_wp;
    logic [CRC_W-1:0]    r_crc;
    logic [CRC_W-1:0]    r_crc_start;

    logic                r_pend_vld;
    t_idx                r_pend_addr;
    logic [BYTE_W-1:0]   r_pend_data;

    logic                r_out_vld;
    logic [BYTE_W-1:0]   r_out_pool;
    logic [CRC_W-1:0]    r_out_crc;

    // pool memory and its per-entry valid bits
    logic [BYTE_W-1:0]   r_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] r_vld;

    // read side: registered data plus what is needed to correct it
    logic [BYTE_W-1:0]   r_q0, r_q1;
    logic                r_rv0, r_rv1;
    logic                r_hit0, r_hit1;
    logic [BYTE_W-1:0]   r_wd_prev;

    // ---------------------------------------------------------------
    // Combinational
    // ---------------------------------------------------------------
    t_cmd                in_cmd;
    logic                pop;
    logic                clear_fire;
    logic                out_free;
    logic                out_load;
    logic [BYTE_W-1:0]   out_pool;
    logic [CRC_W-1:0]    out_crc;
    logic [CRC_W-1:0]    crc_next;
    t_idx                ta_in, tb_in, ridx_in;
    t_idx                ra0, ra1;
    logic                we;
    t_idx                waddr;
    logic [BYTE_W-1:0]   wdata;
    logic [BYTE_W-1:0]   c0, c1;
    logic [BYTE_W-1:0]   v_wp, v_a, v_b;

    assign in_cmd   = t_cmd'(r_in_cmd);
    assign out_free = !r_out_vld || i_ready;
    assign crc_next = crc16_byte(r_crc, r_in_byte);
    assign ta_in    = t_idx'(r_crc[BYTE_W-1:0]);
    assign tb_in    = t_idx'(r_crc[CRC_W-1:BYTE_W]);
    assign ridx_in  = t_idx'(r_in_ridx);

    // read data corrected for a write in the read cycle and for invalid entries
    assign c0 = r_hit0 ? r_wd_prev : (r_rv0 ? r_q0 : '0);
    assign c1 = r_hit1 ? r_wd_prev : (r_rv1 ? r_q1 : '0);

    assign v_wp = c0 + r_cur_byte;
    // first target may be the entry just updated at the write position
    assign v_a  = ((r_ta == r_wp) ? v_wp : c1) ^ r_crc[CRC_W-1:BYTE_W];
    // write-position overlap is already forwarded into c0
    assign v_b  = ((r_tb == r_ta) ? r_va : c0) ^ r_crc[BYTE_W-1:0];

    assign o_ready = !r_in_vld || pop;

    always_comb begin
        n_state    = r_state;
        pop        = 1'b0;
        clear_fire = 1'b0;
        out_load   = 1'b0;
        out_pool   = '0;
        out_crc    = r_crc;
        ra0        = r_wp;
        ra1        = ta_in;
        unique case (r_state)
            ST_IDLE: begin
                if (r_in_vld) begin
                    unique case (in_cmd)
                        CMD_MIX: begin
                            pop     = 1'b1;
                            n_state = ST_MIX2;
                        end
                        CMD_READ: begin
                            ra0     = ridx_in;
                            pop     = 1'b1;
                            n_state = ST_RD2;
                        end
                        CMD_CLEAR: begin
                            if (out_free) begin
                                pop        = 1'b1;
                                clear_fire = 1'b1;
                                out_load   = 1'b1;
                                out_crc    = r_crc_start;
                            end
                        end
                        default: begin
                            // unused command: no state change, report CRC
                            if (out_free) begin
                                pop      = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_MIX2: begin
                ra0     = r_tb;
                n_state = ST_MIX3;
            end
            ST_MIX3: begin
                ra0 = r_tb;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_RD2: begin
                ra0 = r_ridx;
                if (out_free) begin
                    out_load = 1'b1;
                    out_pool = c0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // single write port: deferred second-target write, then in-flight steps
    always_comb begin
        we    = 1'b0;
        waddr = r_wp;
        wdata = v_wp;
        priority if (r_pend_vld) begin
            we    = 1'b1;
            waddr = r_pend_addr;
            wdata = r_pend_data;
        end else if (r_state == ST_MIX2) begin
            we    = 1'b1;
            waddr = r_wp;
            wdata = v_wp;
        end else if (r_state == ST_MIX3) begin
            we    = 1'b1;
            waddr = r_ta;
            wdata = r_va;
        end
    end

    // ---------------------------------------------------------------
    // Pool memory
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_q0      <= r_mem[ra0];
        r_q1      <= r_mem[ra1];
        r_rv0     <= r_vld[ra0];
        r_rv1     <= r_vld[ra1];
        r_hit0    <= we && (waddr == ra0);
        r_hit1    <= we && (waddr == ra1);
        r_wd_prev <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (clear_fire) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[waddr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Control and state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_wp        <= '0;
            r_crc       <= '0;
            r_crc_start <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_crc_start <= i_cfg_data;
            end

            if (i_valid && o_ready) begin
                r_in_vld <= 1'b1;
            end else if (pop) begin
                r_in_vld <= 1'b0;
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end

            r_pend_vld <= (r_state == ST_MIX3) && out_free;

            if (clear_fire) begin
                r_wp  <= '0;
                r_crc <= r_crc_start;
            end else if (r_state == ST_IDLE && pop && in_cmd == CMD_MIX) begin
                r_crc <= crc_next;
            end else if (r_state == ST_MIX2) begin
                r_wp <= t_idx'(r_wp + 1'b1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd  <= i_command;
            r_in_byte <= i_seed_byte;
            r_in_ridx <= i_read_index;
        end
        if (r_state == ST_IDLE && pop) begin
            r_cur_byte <= r_in_byte;
            r_ta       <= ta_in;
            r_tb       <= tb_in;
            r_ridx     <= ridx_in;
        end
        if (r_state == ST_MIX2) begin
            r_va <= v_a;
        end
        if (r_state == ST_MIX3) begin
            r_pend_addr <= r_tb;
            r_pend_data <= v_b;
        end
        if (out_load) begin
            r_out_pool <= out_pool;
            r_out_crc  <= out_crc;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_pool_byte = r_out_pool;
    assign o_crc_now   = r_out_crc;

`ifndef SYNTHESIS
    // deferred write only lands between transactions
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == ST_IDLE))
        else $error("deferred pool write outside idle step");

    // the add step always runs into the first XOR step
    a_mix_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX2) |=> (r_state == ST_MIX3))
        else $error("mix sequence broken");

    // finishing a mix schedules the second-target write
    a_mix_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX3 && out_free) |=> (r_pend_vld && r_out_vld))
        else $error("mix completed without deferred write or result");

    // a clear empties the pool, rewinds the position and reloads the CRC start value
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear_fire |=> (r_vld == '0 && r_wp == '0 && r_crc == $past(r_crc_start)))
        else $error("clear did not reset pool state");

    // a result held under back-pressure does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> (r_out_vld && $stable(r_out_crc)
            && $stable(r_out_pool)))
        else $error("stalled result overwritten");
`endif

endmodule
